FILE: sv/sit_pkg.sv
// Shared types and constants for the segment intersection test unit.
`timescale 1ns / 1ps

package sit_pkg;

    // Coordinate width, signed Q12.4 at the default.
    localparam int COORD_W = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg1_start_x;
        logic signed [COORD_W-1:0] seg1_start_y;
        logic signed [COORD_W-1:0] seg1_end_x;
        logic signed [COORD_W-1:0] seg1_end_y;
        logic signed [COORD_W-1:0] seg2_start_x;
        logic signed [COORD_W-1:0] seg2_start_y;
        logic signed [COORD_W-1:0] seg2_end_x;
        logic signed [COORD_W-1:0] seg2_end_y;
    } seg_word_t;

    typedef struct packed {
        logic hit;
        logic parallel_lines;
    } res_word_t;

endpackage

FILE: sv/segment_intersection_test_unit.sv
// Segment intersection test: six-stage pipeline from segment pair to hit flags.
// Each accepted word moves through stage registers one to six in order; stage six drives the output.
// Throughput: one word per cycle unless the output stalls; each stage loads whenever
// it is empty or its successor moves, so bubbles close up under a stalled output.
// Reset: rst_n clears every stage valid bit; the pipeline comes up empty.
// Stage work: operands, line constant, cross products, determinant, bound products, compare.
`timescale 1ns / 1ps

module segment_intersection_test_unit
    import sit_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      seg_valid,
    output logic      seg_stall,
    input  seg_word_t seg_word,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res_word
);

    localparam int AB_W = COORD_W + 1;
    localparam int PR_W = 2 * COORD_W;
    localparam int C_W  = 2 * COORD_W + 1;
    localparam int DP_W = 2 * COORD_W + 2;
    localparam int D_W  = 2 * COORD_W + 3;
    localparam int CP_W = 3 * COORD_W + 2;
    localparam int N_W  = 3 * COORD_W + 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [AB_W-1:0]    ab_t;
    typedef logic signed [PR_W-1:0]    pr_t;
    typedef logic signed [C_W-1:0]     c_t;
    typedef logic signed [DP_W-1:0]    dp_t;
    typedef logic signed [D_W-1:0]     d_t;
    typedef logic signed [CP_W-1:0]    cp_t;
    typedef logic signed [N_W-1:0]     n_t;

    typedef struct packed {
        logic horiz;
        logic vert;
        ab_t  a;
        ab_t  b;
        pr_t  p;
        pr_t  q;
    } raw_line_t;

    typedef struct packed {
        ab_t a;
        ab_t b;
        c_t  c;
    } line_t;

    typedef struct packed {
        seg_word_t pts;
        logic      ovx;
        logic      ovy;
    } geom_t;

    typedef struct packed {
        dp_t da;
        dp_t db;
        cp_t xa;
        cp_t xb;
        cp_t ya;
        cp_t yb;
    } prod_t;

    typedef struct packed {
        d_t d;
        n_t xn;
        n_t yn;
    } det_t;

    typedef struct packed {
        logic par;
        n_t   xn;
        n_t   yn;
        n_t   x10;
        n_t   x11;
        n_t   x20;
        n_t   x21;
        n_t   y10;
        n_t   y11;
        n_t   y20;
        n_t   y21;
    } bnd_t;

    // Line a*x + b*y = c; axis-aligned lines are normalized, c comes next stage.
    function automatic raw_line_t mk_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
        raw_line_t l;
        ab_t       ar;
        ab_t       br;
        ar      = AB_W'(y0) - AB_W'(y1);
        br      = AB_W'(x1) - AB_W'(x0);
        l.horiz = (ar == '0);
        l.vert  = (br == '0);
        l.a     = (l.vert && !l.horiz) ? AB_W'(1) : ar;
        l.b     = l.horiz ? AB_W'(1) : br;
        l.p     = PR_W'(x1) * PR_W'(y0);
        l.q     = PR_W'(x0) * PR_W'(y1);
        return l;
    endfunction

    function automatic line_t fin_line(raw_line_t r, coord_t x0, coord_t y0);
        line_t l;
        l.a = r.a;
        l.b = r.b;
        if (r.horiz)
        begin
            l.c = C_W'(y0);
        end
        else if (r.vert)
        begin
            l.c = C_W'(x0);
        end
        else
        begin
            l.c = C_W'(r.p) - C_W'(r.q);
        end
        return l;
    endfunction

    function automatic logic overlap(coord_t a0, coord_t a1, coord_t b0, coord_t b1);
        coord_t lo_a;
        coord_t hi_a;
        coord_t lo_b;
        coord_t hi_b;
        lo_a = (a0 < a1) ? a0 : a1;
        hi_a = (a0 > a1) ? a0 : a1;
        lo_b = (b0 < b1) ? b0 : b1;
        hi_b = (b0 > b1) ? b0 : b1;
        return ((lo_a > lo_b) ? lo_a : lo_b) <= ((hi_a < hi_b) ? hi_a : hi_b);
    endfunction

    // num/d between p and q in either order; scaling both bounds by d keeps it sign-safe
    function automatic logic between(n_t p, n_t q, n_t v);
        return (p <= v && v <= q) || (v <= p && q <= v);
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    geom_t     g1_reg, g2_reg, g3_reg, g4_reg, g5_reg;
    geom_t     g1_next;
    raw_line_t r1_reg, r2_reg, r1_next, r2_next;
    line_t     l1_reg, l2_reg, l1_next, l2_next;
    prod_t     p_reg, p_next;
    det_t      d_reg, d_next;
    bnd_t      b_reg, b_next;
    res_word_t res_reg, res_next;

    assign en6       = !v6_reg || !res_stall;
    assign en5       = !v5_reg || en6;
    assign en4       = !v4_reg || en5;
    assign en3       = !v3_reg || en4;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign seg_stall = !en1;
    assign res_valid = v6_reg;
    assign res_word  = res_reg;

    always_comb
    begin
        g1_next.pts = seg_word;
        g1_next.ovx = overlap(seg_word.seg1_start_x, seg_word.seg1_end_x,
                              seg_word.seg2_start_x, seg_word.seg2_end_x);
        g1_next.ovy = overlap(seg_word.seg1_start_y, seg_word.seg1_end_y,
                              seg_word.seg2_start_y, seg_word.seg2_end_y);
        r1_next = mk_line(seg_word.seg1_start_x, seg_word.seg1_start_y,
                          seg_word.seg1_end_x, seg_word.seg1_end_y);
        r2_next = mk_line(seg_word.seg2_start_x, seg_word.seg2_start_y,
                          seg_word.seg2_end_x, seg_word.seg2_end_y);
    end

    always_comb
    begin
        l1_next = fin_line(r1_reg, g1_reg.pts.seg1_start_x, g1_reg.pts.seg1_start_y);
        l2_next = fin_line(r2_reg, g1_reg.pts.seg2_start_x, g1_reg.pts.seg2_start_y);
    end

    always_comb
    begin
        p_next.da = DP_W'(l1_reg.a) * DP_W'(l2_reg.b);
        p_next.db = DP_W'(l1_reg.b) * DP_W'(l2_reg.a);
        p_next.xa = CP_W'(l1_reg.c) * CP_W'(l2_reg.b);
        p_next.xb = CP_W'(l2_reg.c) * CP_W'(l1_reg.b);
        p_next.ya = CP_W'(l2_reg.c) * CP_W'(l1_reg.a);
        p_next.yb = CP_W'(l1_reg.c) * CP_W'(l2_reg.a);
    end

    always_comb
    begin
        d_next.d  = D_W'(p_reg.da) - D_W'(p_reg.db);
        d_next.xn = N_W'(p_reg.xa) - N_W'(p_reg.xb);
        d_next.yn = N_W'(p_reg.ya) - N_W'(p_reg.yb);
    end

    always_comb
    begin
        b_next.par = (d_reg.d == '0);
        b_next.xn  = d_reg.xn;
        b_next.yn  = d_reg.yn;
        b_next.x10 = N_W'(d_reg.d) * N_W'(g4_reg.pts.seg1_start_x);
        b_next.x11 = N_W'(d_reg.d) * N_W'(g4_reg.pts.seg1_end_x);
        b_next.x20 = N_W'(d_reg.d) * N_W'(g4_reg.pts.seg2_start_x);
        b_next.x21 = N_W'(d_reg.d) * N_W'(g4_reg.pts.seg2_end_x);
        b_next.y10 = N_W'(d_reg.d) * N_W'(g4_reg.pts.seg1_start_y);
        b_next.y11 = N_W'(d_reg.d) * N_W'(g4_reg.pts.seg1_end_y);
        b_next.y20 = N_W'(d_reg.d) * N_W'(g4_reg.pts.seg2_start_y);
        b_next.y21 = N_W'(d_reg.d) * N_W'(g4_reg.pts.seg2_end_y);
    end

    always_comb
    begin
        res_next.parallel_lines = b_reg.par;
        if (b_reg.par)
        begin
            // coincident lines only hit where both ranges overlap
            res_next.hit = (b_reg.xn == '0) && (b_reg.yn == '0) && g5_reg.ovx && g5_reg.ovy;
        end
        else
        begin
            res_next.hit = between(b_reg.x10, b_reg.x11, b_reg.xn)
                        && between(b_reg.x20, b_reg.x21, b_reg.xn)
                        && between(b_reg.y10, b_reg.y11, b_reg.yn)
                        && between(b_reg.y20, b_reg.y21, b_reg.yn);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= seg_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            g1_reg <= g1_next;
            r1_reg <= r1_next;
            r2_reg <= r2_next;
        end
        if (en2)
        begin
            g2_reg <= g1_reg;
            l1_reg <= l1_next;
            l2_reg <= l2_next;
        end
        if (en3)
        begin
            g3_reg <= g2_reg;
            p_reg  <= p_next;
        end
        if (en4)
        begin
            g4_reg <= g3_reg;
            d_reg  <= d_next;
        end
        if (en5)
        begin
            g5_reg <= g4_reg;
            b_reg  <= b_next;
        end
        if (en6)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    // input held off only when every stage holds a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        seg_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg))
        else $error("input stalled with an empty stage");

    // a blocked stage five traces back to a stalled, full output stage
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !en5) |-> (v6_reg && res_stall))
        else $error("stage five blocked without output stall");

    // zero determinant scales every bound to zero
    a_par_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && b_reg.par) |-> (b_reg.x10 == '0 && b_reg.y21 == '0))
        else $error("nonzero bound product on parallel lines");
`endif

endmodule
